// ===== hdl/plwarp_pkg.sv =====
// Package for the piecewise linear time warp block.
// Holds request codes, status codes, a width constant and the divider control struct; no dependencies.
`timescale 1ns / 1ps
package plwarp_pkg;
    localparam int unsigned TW = 32;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NOP    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EQUAL = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage

// ===== hdl/plwarp_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Depends on plwarp_pkg for the control struct.
`timescale 1ns / 1ps
module plwarp_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [63:0]          dividend,
    input  logic [31:0]          divisor,
    output plwarp_pkg::div_ctl_t ctl,
    output logic [63:0]          quotient
);
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [33:0] sub;

    always_comb
    begin
        trial     = {rem_reg[31:0], quo_reg[63]};
        sub       = {1'b0, trial} - {2'b00, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (!sub[33])
            begin
                rem_next = sub[32:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start && !busy_reg)
            dvs_reg <= divisor;
    end

    assign quotient  = quo_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("div done without busy");
    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && busy_reg)) else $error("div done while busy");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == 7'd1) |=> done_reg) else $error("div end lost");
endmodule

// ===== hdl/piecewise_linear_time_warp.sv =====
// Piecewise linear time warp: sorted anchor table, segment walk, serial divide.
// Insert: scan for the slot (read, compare), shift later entries up one per cycle, then write.
// Query: walk the segments (read, compare), read the previous anchor, serial divide, finish.
// One word at a time; busy is high from acceptance until the result strobe, which cannot stall.
// Reset (async, rst_n low) empties the table; stores are not cleared.
// Depends on plwarp_pkg and plwarp_div.
`timescale 1ns / 1ps
module piecewise_linear_time_warp #(
    parameter int unsigned MAX_ANCHORS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [31:0] anchor_source,
    input  logic [31:0] anchor_target,
    input  logic [31:0] query_time,
    output logic        result_valid,
    output logic signed [31:0] warped_time,
    output logic [1:0]  status
);
    localparam int unsigned AW = $clog2(MAX_ANCHORS);
    localparam int unsigned CW = $clog2(MAX_ANCHORS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ISCAN, S_ICHK, S_ISHIFT, S_IWRITE,
        S_QSCAN, S_QCHK, S_QPREV, S_QPCHK, S_QCALC, S_QDIV, S_QFIN, S_DONE
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [31:0] s_reg, t_reg, q_reg;
    logic [31:0] sk_reg, tk_reg, sa_reg, ta_reg;
    logic [31:0] ydata_reg;
    logic [1:0]  st_reg;
    logic        neg_reg;
    logic        dstart_reg;
    logic [63:0] dvd_reg;
    logic [31:0] dvs_reg;

    logic [31:0] src_mem [MAX_ANCHORS];
    logic [31:0] tgt_mem [MAX_ANCHORS];
    logic [31:0] rd_s, rd_t;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0] wr_s, wr_t;
    logic        wr_en;

    plwarp_pkg::div_ctl_t dctl;
    logic [63:0] quo;

    plwarp_div u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart_reg),
        .dividend(dvd_reg), .divisor(dvs_reg), .ctl(dctl), .quotient(quo)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            src_mem[wr_addr] <= wr_s;
            tgt_mem[wr_addr] <= wr_t;
        end
        rd_s <= src_mem[rd_addr];
        rd_t <= tgt_mem[rd_addr];
    end

    // memory port control
    always_comb
    begin
        rd_addr = idx_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_s    = rd_s;
        wr_t    = rd_t;
        if (state_reg == S_ICHK)
            rd_addr = AW'(count_reg - CW'(1));
        if (state_reg == S_ISHIFT)
            rd_addr = AW'(idx_reg - CW'(2));
        if (state_reg == S_QPREV)
            rd_addr = AW'(idx_reg - CW'(1));
        if (state_reg == S_ISHIFT && idx_reg != 0)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_reg);
        end
        if (state_reg == S_IWRITE)
        begin
            wr_en = 1'b1;
            wr_s  = s_reg;
            wr_t  = t_reg;
        end
    end

    logic        after;
    logic [31:0] adt, adq, ds;
    logic [34:0] mag;
    logic signed [35:0] yfull;

    assign after = (rd_s > s_reg) || (rd_s == s_reg && rd_t > t_reg);
    assign adt   = (tk_reg >= ta_reg) ? tk_reg - ta_reg : ta_reg - tk_reg;
    assign adq   = (q_reg >= sk_reg) ? q_reg - sk_reg : sk_reg - q_reg;
    assign ds    = sk_reg - sa_reg;
    assign mag   = (quo > 64'h4_0000_0000) ? 35'h4_0000_0000 : quo[34:0];
    assign yfull = neg_reg ? $signed({4'b0, tk_reg}) - $signed({1'b0, mag})
                           : $signed({4'b0, tk_reg}) + $signed({1'b0, mag});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            result_valid <= 1'b0;
            dstart_reg   <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            dstart_reg   <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        s_reg     <= anchor_source;
                        t_reg     <= anchor_target;
                        q_reg     <= query_time;
                        ydata_reg <= '0;
                        st_reg    <= plwarp_pkg::ST_OK;
                        idx_reg   <= '0;
                        unique case (plwarp_pkg::req_t'(req_type))
                            plwarp_pkg::REQ_CLEAR:
                            begin
                                count_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            plwarp_pkg::REQ_INSERT:
                            begin
                                if (count_reg >= CW'(MAX_ANCHORS))
                                begin
                                    st_reg    <= plwarp_pkg::ST_FULL;
                                    state_reg <= S_DONE;
                                end
                                else if (count_reg == 0)
                                    state_reg <= S_IWRITE;
                                else
                                    state_reg <= S_ISCAN;
                            end
                            plwarp_pkg::REQ_QUERY:
                            begin
                                if (count_reg == 0)
                                begin
                                    ydata_reg <= query_time[31] ? 32'h7FFF_FFFF
                                                                : query_time;
                                    st_reg    <= query_time[31] ? plwarp_pkg::ST_SAT
                                                                : plwarp_pkg::ST_OK;
                                    state_reg <= S_DONE;
                                end
                                else
                                    state_reg <= S_QSCAN;
                            end
                            plwarp_pkg::REQ_NOP: state_reg <= S_DONE;
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                // read issued at idx; check next cycle
                S_ISCAN: state_reg <= S_ICHK;
                S_ICHK:
                begin
                    if (after)
                    begin
                        s_reg     <= s_reg;
                        dvs_reg   <= 32'(idx_reg);
                        idx_reg   <= count_reg;
                        state_reg <= S_ISHIFT;
                    end
                    else if (idx_reg + CW'(1) == count_reg)
                    begin
                        idx_reg   <= count_reg;
                        state_reg <= S_IWRITE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_ISCAN;
                    end
                end
                // idx = destination; its data (idx-1) was read in the previous cycle, and idx-2 is read now
                S_ISHIFT:
                begin
                    if (idx_reg == CW'(dvs_reg) + CW'(1))
                    begin
                        idx_reg   <= CW'(dvs_reg);
                        state_reg <= S_IWRITE;
                    end
                    else
                        idx_reg <= idx_reg - CW'(1);
                end
                S_IWRITE:
                begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_DONE;
                end
                S_QSCAN: state_reg <= S_QCHK;
                S_QCHK:
                begin
                    if (idx_reg + CW'(1) < count_reg && !(q_reg < rd_s))
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_QSCAN;
                    end
                    else
                    begin
                        sk_reg <= rd_s;
                        tk_reg <= rd_t;
                        sa_reg <= '0;
                        ta_reg <= '0;
                        state_reg <= (idx_reg == 0) ? S_QCALC : S_QPREV;
                    end
                end
                S_QPREV: state_reg <= S_QPCHK;
                S_QPCHK:
                begin
                    sa_reg    <= rd_s;
                    ta_reg    <= rd_t;
                    state_reg <= S_QCALC;
                end
                S_QCALC:
                begin
                    if (sk_reg == sa_reg)
                    begin
                        ydata_reg <= tk_reg[31] ? 32'h7FFF_FFFF : tk_reg;
                        if (tk_reg[31])
                            st_reg <= plwarp_pkg::ST_SAT;
                        else if (idx_reg != 0)
                            st_reg <= plwarp_pkg::ST_EQUAL;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        neg_reg <= ((tk_reg < ta_reg) != (q_reg < sk_reg))
                                   && adt != 0 && adq != 0;
                        dvd_reg    <= 64'(adt) * 64'(adq) + 64'(ds >> 1);
                        dvs_reg    <= ds;
                        dstart_reg <= 1'b1;
                        state_reg  <= S_QDIV;
                    end
                end
                S_QDIV:
                begin
                    if (dctl.done)
                        state_reg <= S_QFIN;
                end
                S_QFIN:
                begin
                    if (yfull > 36'sh0_7FFF_FFFF)
                    begin
                        ydata_reg <= 32'h7FFF_FFFF;
                        st_reg    <= plwarp_pkg::ST_SAT;
                    end
                    else if (yfull < -36'sh0_8000_0000)
                    begin
                        ydata_reg <= 32'h8000_0000;
                        st_reg    <= plwarp_pkg::ST_SAT;
                    end
                    else
                        ydata_reg <= yfull[31:0];
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    result_valid <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign warped_time = ydata_reg;
    assign status      = st_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ANCHORS)) else $error("anchor count overflow");
    a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("double result strobe");
    a_div_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        dctl.busy |-> state_reg == S_QDIV) else $error("divider busy outside query");
endmodule
